// ===== rtl/bht_pkg.sv =====
`default_nettype none
package bht_pkg;
	localparam int MaxBuckets = 64;
	localparam int SlotsPerBucket = 4;
	localparam int TotalSlots = MaxBuckets * SlotsPerBucket;
	localparam int SlotW = $clog2(TotalSlots);
	localparam int BucketW = $clog2(MaxBuckets);
	localparam int SlotIdxW = (SlotsPerBucket > 1) ? $clog2(SlotsPerBucket) : 1;
	localparam int HashW = 32;
	localparam logic [HashW-1:0] HashSeed = 32'd216;
	localparam logic [HashW-1:0] HashMul = 32'd167;

	typedef enum logic [1:0] {
		REQ_UPSERT = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_UPDATE = 2'd2,
		REQ_GET = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_PRESENT = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [63:0] key_bytes;
		logic [31:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] read_data;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_MOD,
		S_READ,
		S_CHECK,
		S_OUT
	} fsm_t;
endpackage
`default_nettype wire

// ===== rtl/bht_ram.sv =====
`default_nettype none
module bht_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/bht_hash.sv =====
`default_nettype none
// iterative hash and modulo: one byte per cycle, then one restoring bit per cycle
module bht_hash (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] key,
	input wire logic [6:0] divisor,
	output logic done,
	output logic [bht_pkg::BucketW-1:0] bucket
);
	import bht_pkg::*;

	logic [HashW-1:0] hash_q;
	logic [63:0] key_q;
	logic [3:0] byte_q;
	logic [5:0] bit_q;
	logic [6:0] rem_q;
	logic phase_q, busy_q;
	logic [31:0] hb;
	logic [7:0] rem_sh;

	assign hb = {{24{key_q[7]}}, key_q[7:0]};
	assign rem_sh = {rem_q, hash_q[HashW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				phase_q <= 1'b0;
				hash_q <= HashSeed;
				key_q <= key;
				byte_q <= 4'd0;
			end else if (busy_q && !phase_q) begin
				// advance one key byte, stop at NUL
				if (byte_q == 4'd8 || key_q[7:0] == 8'd0) begin
					phase_q <= 1'b1;
					bit_q <= 6'd0;
					rem_q <= 7'd0;
				end else begin
					hash_q <= (hash_q ^ hb) * HashMul;
					key_q <= key_q >> 8;
					byte_q <= byte_q + 4'd1;
				end
			end else if (busy_q) begin
				// one remainder bit per cycle
				if ({1'b0, rem_sh} >= {2'b0, divisor})
					rem_q <= 7'(rem_sh - {1'b0, divisor});
				else
					rem_q <= rem_sh[6:0];
				hash_q <= hash_q << 1;
				bit_q <= bit_q + 6'd1;
				if (bit_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign bucket = rem_q[BucketW-1:0];
endmodule
`default_nettype wire

// ===== rtl/bucketed_hash_table.sv =====
`default_nettype none
// Bucketed hash table: key-value store, 64 buckets of 4 slots.
// Input channel in_valid/in_stall carries {req_type, key_bytes, write_data};
// output channel out_valid/out_stall carries {status, read_data}.
// One request is handled at a time: in_stall is high from acceptance
// until the result has left the output register.
// Steps: the key bytes before the first NUL are hashed, then a bit-serial
// modulo by bucket_count gives the bucket; then each slot of the bucket is
// read and checked in turn (S_READ, then S_CHECK), 1 to 4 slots, until a
// slot decides the request or the last slot has been checked.
// The next request can be accepted in the cycle after the result is taken.
// The slot memories share one address for read and write; a write lands at the checked slot.
// cfg_we/cfg_wdata write bucket_count (reset 64; 0 acts as 1, >64 as 64).
// Reset clears all slot valid bits and the controller at once.
// A stalled result holds in the output register; no new request enters.
module bucketed_hash_table (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire bht_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output bht_pkg::out_item_t out_data,
	input wire logic cfg_we,
	input wire logic [6:0] cfg_wdata
);
	import bht_pkg::*;

	fsm_t state_q, state_d;
	logic [6:0] bc_q, bc_eff;
	in_item_t req_q;
	logic [63:0] nkey;
	logic hstart, hdone;
	logic [BucketW-1:0] bucket;
	logic [BucketW-1:0] bucket_q;
	logic [SlotIdxW-1:0] idx_q;
	logic [TotalSlots-1:0] valid_q;
	logic [SlotW-1:0] addr;
	logic [63:0] rkey;
	logic [31:0] rval;
	logic we;
	logic [31:0] wval;
	logic empty, match, last, finish;
	logic [1:0] st;
	logic [31:0] rd;

	// normalize key: clear bytes from first NUL on
	always_comb begin
		logic z;
		z = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (in_data.key_bytes[8*i +: 8] == 8'd0) z = 1'b1;
			nkey[8*i +: 8] = z ? 8'd0 : in_data.key_bytes[8*i +: 8];
		end
	end

	assign bc_eff = (bc_q == 7'd0) ? 7'd1 : ((bc_q > 7'd64) ? 7'd64 : bc_q);
	assign hstart = (state_q == S_IDLE) && in_valid;

	bht_hash u_hash (.clk, .arst_n, .start(hstart), .key(nkey), .divisor(bc_eff),
		.done(hdone), .bucket);

	assign addr = SlotW'({bucket_q, idx_q});

	bht_ram #(.Width(64), .Depth(TotalSlots)) u_key (.clk, .we,
		.waddr(addr), .wdata(req_q.key_bytes), .raddr(addr), .rdata(rkey));
	bht_ram #(.Width(32), .Depth(TotalSlots)) u_val (.clk, .we,
		.waddr(addr), .wdata(wval), .raddr(addr), .rdata(rval));

	// decide on the slot under check
	assign empty = !valid_q[addr];
	assign match = !empty && rkey == req_q.key_bytes;
	assign last = idx_q == SlotIdxW'(SlotsPerBucket - 1);
	always_comb begin
		we = 1'b0;
		wval = req_q.write_data;
		finish = last;
		st = (req_q.req_type == REQ_UPDATE || req_q.req_type == REQ_GET) ?
			ST_NOT_FOUND : ST_FULL;
		rd = 32'd0;
		case (req_q.req_type)
			REQ_UPSERT: if (empty || match) begin
				we = 1'b1; finish = 1'b1; st = ST_DONE; rd = req_q.write_data;
			end
			REQ_INSERT: if (empty) begin
				we = 1'b1; finish = 1'b1; st = ST_DONE; rd = req_q.write_data;
			end else if (match) begin
				finish = 1'b1; st = ST_PRESENT; rd = rval;
			end
			REQ_UPDATE: if (empty) finish = 1'b1;
			else if (match) begin
				we = 1'b1; finish = 1'b1; st = ST_DONE; rd = req_q.write_data;
			end
			default: if (empty) finish = 1'b1;
			else if (match) begin
				finish = 1'b1; st = ST_DONE; rd = rval;
			end
		endcase
		if (state_q != S_CHECK) we = 1'b0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_HASH;
			S_HASH: if (hdone) state_d = S_READ;
			S_READ: state_d = S_CHECK;
			S_CHECK: state_d = finish ? S_OUT : S_READ;
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = state_q != S_IDLE;
		out_valid = state_q == S_OUT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bc_q <= 7'd64;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) bc_q <= cfg_wdata;
			if (we) valid_q[addr] <= 1'b1;
		end
	end

	// hold request and slot cursor
	always_ff @(posedge clk) begin
		if (hstart) begin
			req_q.req_type <= in_data.req_type;
			req_q.key_bytes <= nkey;
			req_q.write_data <= in_data.write_data;
		end
		if (hdone) begin
			bucket_q <= bucket;
			idx_q <= '0;
		end
		if (state_q == S_CHECK) begin
			idx_q <= idx_q + SlotIdxW'(1);
			if (finish) begin
				out_data.status <= st;
				out_data.read_data <= rd;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/bht_checker.sv =====
`default_nettype none
module bht_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire bht_pkg::out_item_t out_data
);
	import bht_pkg::*;

	// result held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	// no request taken while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("request taken during output");
	// accepted request blocks the input next cycle
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("input not blocked");
	// failure yields zero data
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_NOT_FOUND || out_data.status == ST_FULL)
		|-> out_data.read_data == 32'd0) else $error("nonzero data on failure");
endmodule

bind bucketed_hash_table bht_checker u_chk (.clk, .arst_n, .in_valid, .in_stall,
	.out_valid, .out_stall, .out_data);
`default_nettype wire
